// File: rtl/core/max_queue_two_stacks_assert.svh
// ---------------------------------------------------------------------------
// Max queue assertion macros
// Clocked assertion forms shared by the checker of the max queue block.
// ---------------------------------------------------------------------------
`ifndef MAX_QUEUE_TWO_STACKS_ASSERT_SVH
`define MAX_QUEUE_TWO_STACKS_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MQTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max queue check failed");

// consequent checked in the cycle after the antecedent
`define MQTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("max queue check failed");

`endif

// File: rtl/core/mqts_pkg.sv
// ---------------------------------------------------------------------------
// Max queue package
// Sizes, entry and request types, codes and the signed maximum helper.
// ---------------------------------------------------------------------------
package mqts_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic signed [31:0]   data_t;
  typedef logic [1:0]           status_t;

  localparam cnt_t DEPTH_C = CW'(DEPTH);

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef struct packed {
    data_t value;
    data_t max;
  } entry_t;

  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XFER_RD,
    S_XFER_WR,
    S_DEQ_RD,
    S_DEQ_VAL,
    S_MAX_CAP,
    S_FINISH
  } state_t;

  function automatic data_t smax(data_t a, data_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: rtl/core/mqts_in_if.sv
// ---------------------------------------------------------------------------
// Max queue request channel
// Valid/ready channel carrying one operation and its value.
// ---------------------------------------------------------------------------
interface mqts_in_if;
  import mqts_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  data_t value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// File: rtl/core/mqts_out_if.sv
// ---------------------------------------------------------------------------
// Max queue result channel
// Valid/ready channel carrying one result per operation.
// ---------------------------------------------------------------------------
interface mqts_out_if;
  import mqts_pkg::*;

  logic    valid;
  logic    ready;
  data_t   dequeued_value;
  data_t   current_max;
  logic    is_empty;
  status_t status;

  modport source (output valid, output dequeued_value, output current_max,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input dequeued_value, input current_max,
                  input is_empty, input status, output ready);
endinterface

// File: rtl/core/mqts_store.sv
// ---------------------------------------------------------------------------
// Max queue store
// Shared entry memory of both stacks: value and running maximum per entry,
// one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module mqts_store (
  input  logic              clk,
  input  mqts_pkg::mem_req_t req,
  output mqts_pkg::entry_t   rd_data
);
  import mqts_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

// File: rtl/core/mqts_ctrl.sv
// ---------------------------------------------------------------------------
// Max queue controller
// Stack pointers, cached top maxima, transfer walk and result register.
// ---------------------------------------------------------------------------
module mqts_ctrl (
  input  logic               clk,
  input  logic               rst,
  mqts_in_if.sink            item,
  mqts_out_if.source         result,
  output mqts_pkg::mem_req_t mem_req,
  input  mqts_pkg::entry_t   rd_data
);
  import mqts_pkg::*;

  state_t  state, state_next;
  cnt_t    bcnt, bcnt_next;
  cnt_t    fsize, fsize_next;
  data_t   bmax, bmax_next;
  data_t   fmax, fmax_next;
  data_t   deq, deq_next;
  status_t status, status_next;
  logic    out_load;

  logic    full;
  logic    empty_q;
  addr_t   top_addr;
  addr_t   xfer_rd_addr;
  addr_t   xfer_wr_addr;
  data_t   enq_max;
  data_t   xfer_max;
  data_t   max_now;

  always_comb begin
    full         = (bcnt + fsize) == DEPTH_C;
    empty_q      = (bcnt == '0) && (fsize == '0);
    top_addr     = AW'(DEPTH_C - fsize);
    xfer_rd_addr = AW'(bcnt - CW'(1));
    xfer_wr_addr = AW'(DEPTH_C - fsize - CW'(1));
    enq_max      = (bcnt == '0) ? item.value : smax(bmax, item.value);
    xfer_max     = (fsize == '0) ? rd_data.value : smax(rd_data.value, fmax);
    if (empty_q) begin
      max_now = '0;
    end else if (bcnt == '0) begin
      max_now = fmax;
    end else if (fsize == '0) begin
      max_now = bmax;
    end else begin
      max_now = smax(bmax, fmax);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bcnt  <= '0;
      fsize <= '0;
    end else begin
      state <= state_next;
      bcnt  <= bcnt_next;
      fsize <= fsize_next;
    end
  end

  always_ff @(posedge clk) begin
    bmax   <= bmax_next;
    fmax   <= fmax_next;
    deq    <= deq_next;
    status <= status_next;
  end

  always_comb begin
    state_next  = state;
    bcnt_next   = bcnt;
    fsize_next  = fsize;
    bmax_next   = bmax;
    fmax_next   = fmax;
    deq_next    = deq;
    status_next = status;
    out_load    = 1'b0;
    item.ready  = 1'b0;
    mem_req     = '0;

    unique case (state)
      S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          deq_next    = '0;
          status_next = ST_OK;
          if (item.func == FUNC_ENQ) begin
            state_next = S_FINISH;
            if (full) begin
              status_next = ST_FULL;
            end else begin
              mem_req.wr_en         = 1'b1;
              mem_req.wr_addr       = AW'(bcnt);
              mem_req.wr_data.value = item.value;
              mem_req.wr_data.max   = enq_max;
              bmax_next             = enq_max;
              bcnt_next             = bcnt + CW'(1);
            end
          end else if (empty_q) begin
            status_next = ST_EMPTY;
            state_next  = S_FINISH;
          end else if (fsize == '0) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = xfer_rd_addr;
            state_next      = S_XFER_WR;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = top_addr;
            state_next      = S_DEQ_VAL;
          end
        end
      end
      S_XFER_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = xfer_rd_addr;
        state_next      = S_XFER_WR;
      end
      S_XFER_WR: begin
        mem_req.wr_en         = 1'b1;
        mem_req.wr_addr       = xfer_wr_addr;
        mem_req.wr_data.value = rd_data.value;
        mem_req.wr_data.max   = xfer_max;
        fmax_next             = xfer_max;
        fsize_next            = fsize + CW'(1);
        bcnt_next             = bcnt - CW'(1);
        state_next            = (bcnt == CW'(1)) ? S_DEQ_RD : S_XFER_RD;
      end
      S_DEQ_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = top_addr;
        state_next      = S_DEQ_VAL;
      end
      S_DEQ_VAL: begin
        deq_next   = rd_data.value;
        fsize_next = fsize - CW'(1);
        if (fsize > CW'(1)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = top_addr + AW'(1);
          state_next      = S_MAX_CAP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MAX_CAP: begin
        fmax_next  = rd_data.max;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.dequeued_value <= deq;
      result.current_max    <= max_now;
      result.is_empty       <= empty_q;
      result.status         <= status;
    end
  end
endmodule

// File: rtl/core/max_queue_two_stacks.sv
// ---------------------------------------------------------------------------
// Max queue from two stacks
// FIFO of signed 32-bit values that reports the maximum of its contents.
// ---------------------------------------------------------------------------
// Usage:
//   item   : request channel; func selects enqueue or dequeue, value is the
//            operand of an enqueue. One request is taken at a time.
//   result : one result per request: dequeued value, maximum after the
//            step (0 when empty), empty flag and status code.
// Steps: an enqueue, a refused request or a dequeue on empty goes straight
//   to the finish state; a dequeue from a nonempty front stack reads the top
//   entry and, if more values remain, the new top's maximum; a dequeue on an
//   empty front stack first moves the back stack over, value by value.
// Each move waits for its registered read before it writes the entry with
// its new maximum. Each value moves once.
// Reset empties both stacks; the memory itself is not cleared.
// A stalled result holds in the output register; the next request is
// accepted meanwhile and its result waits until the register frees.
// ---------------------------------------------------------------------------
module max_queue_two_stacks (
  input  logic clk,
  input  logic rst,
  mqts_in_if.sink    item,
  mqts_out_if.source result
);
  import mqts_pkg::*;

  mem_req_t mem_req;
  entry_t   rd_data;

  mqts_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  mqts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .result  (result),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );
endmodule

// File: rtl/core/mqts_checker.sv
// ---------------------------------------------------------------------------
// Max queue checker
// Port-level checks on the request and result channels, bound to the top.
// ---------------------------------------------------------------------------
`include "max_queue_two_stacks_assert.svh"

module mqts_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input mqts_pkg::data_t   result_dequeued_value,
  input mqts_pkg::data_t   result_current_max,
  input logic              result_is_empty,
  input mqts_pkg::status_t result_status
);
  import mqts_pkg::*;

  logic        res_stall;
  logic        res_empty;
  logic        res_deq_empty;
  logic [66:0] res_payload;

  assign res_stall     = result_valid && !result_ready;
  assign res_empty     = result_valid && result_is_empty;
  assign res_deq_empty = result_valid && (result_status == ST_EMPTY);
  assign res_payload   = {result_dequeued_value, result_current_max,
                          result_is_empty, result_status};

  `MQTS_ASSERT_NEXT(a_result_hold, res_stall, result_valid)
  `MQTS_ASSERT_NEXT(a_result_stable, res_stall, $stable(res_payload))
  `MQTS_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready)
  `MQTS_ASSERT_SAME(a_empty_max_zero, res_empty, result_current_max == '0)
  `MQTS_ASSERT_SAME(a_deq_on_empty, res_deq_empty, result_is_empty && (result_dequeued_value == '0))
endmodule

bind max_queue_two_stacks mqts_checker u_mqts_checker (
  .clk                   (clk),
  .rst                   (rst),
  .item_valid            (item.valid),
  .item_ready            (item.ready),
  .result_valid          (result.valid),
  .result_ready          (result.ready),
  .result_dequeued_value (result.dequeued_value),
  .result_current_max    (result.current_max),
  .result_is_empty       (result.is_empty),
  .result_status         (result.status)
);

// File: bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Max queue testbench
// Sends enqueue and dequeue transactions to the two-stack max queue. A
// scoreboard keeps the FIFO contents, predicts each result, and compares
// every field of each result transaction. The sender and the receiver idle
// at random in several phases, and one long receiver hold fills the block.
// ---------------------------------------------------------------------------
module tb;
  import mqts_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    data_t   deq;
    data_t   peak;
    logic    empty;
    status_t status;
  } maxq_result_t;

  class maxq_tracker;
    data_t        contents[$];
    maxq_result_t pending_results[$];
    int           mismatches;

    function void record_op(logic func, data_t value);
      maxq_result_t r;
      r.deq    = '0;
      r.status = ST_OK;
      if (func == FUNC_ENQ) begin
        if (contents.size() == DEPTH) r.status = ST_FULL;
        else contents.push_back(value);
      end else begin
        if (contents.size() == 0) r.status = ST_EMPTY;
        else r.deq = contents.pop_front();
      end
      r.empty = (contents.size() == 0);
      r.peak  = '0;
      foreach (contents[i])
        if (i == 0 || contents[i] > r.peak) r.peak = contents[i];
      pending_results.push_back(r);
    endfunction

    function void report(string field, data_t exp_val, data_t act_val);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d at %0t",
                 field, exp_val, act_val, $time);
    endfunction

    function void check_result(data_t deq, data_t peak, logic empty, status_t status);
      maxq_result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no pending transaction: dequeued %0d at %0t",
                   deq, $time);
        return;
      end
      e = pending_results.pop_front();
      if (deq !== e.deq) report("dequeued_value", e.deq, deq);
      if (peak !== e.peak) report("current_max", e.peak, peak);
      if (empty !== e.empty) report("is_empty", data_t'(e.empty), data_t'(empty));
      if (status !== e.status) report("status", data_t'(e.status), data_t'(status));
    endfunction

    function int depth_used();
      return contents.size();
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct;
  int   stall_pct;
  logic hold_rx;
  int   idle_cycles;

  maxq_tracker tracker;

  mqts_in_if  item_if ();
  mqts_out_if result_if ();

  max_queue_two_stacks uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return '0;
      3: return -1;
      4: return data_t'($urandom_range(0, 20)) - 10;
      default: return data_t'($urandom());
    endcase
  endfunction

  task automatic send_op(logic func, data_t value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.func  <= func;
    item_if.value <= value;
    do @(posedge clk); while (!item_if.ready);
    tracker.record_op(func, value);
  endtask

  task automatic run_phase(int idle_pct, int stall);
    int sent;
    int kind;
    int len;
    int enq_pct;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    sent = 0;
    kind = 0;
    while (sent < PHASE_ITEMS) begin
      case (kind)
        0: begin
          len = DEPTH - tracker.depth_used() + $urandom_range(1, 3);
          repeat (len) send_op(FUNC_ENQ, pick_value());
        end
        1: begin
          len = tracker.depth_used() + $urandom_range(1, 2);
          repeat (len) send_op(FUNC_DEQ, pick_value());
        end
        default: begin
          len     = $urandom_range(10, 40);
          enq_pct = $urandom_range(30, 70);
          repeat (len)
            send_op(($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                    pick_value());
        end
      endcase
      sent += len;
      kind = $urandom_range(0, 3);
    end
  endtask

  initial begin
    do @(posedge clk); while (rst);
    forever begin
      result_if.ready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
      @(posedge clk);
      if (result_if.valid && result_if.ready)
        tracker.check_result(result_if.dequeued_value, result_if.current_max,
                             result_if.is_empty, result_if.status);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    tracker         = new();
    item_if.valid   = 1'b0;
    item_if.func    = FUNC_ENQ;
    item_if.value   = '0;
    result_if.ready = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_rx         = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_op(FUNC_DEQ, 32'sh12345678);
    send_op(FUNC_ENQ, 32'sh80000000);
    send_op(FUNC_DEQ, '0);
    send_op(FUNC_ENQ, 32'sh7fffffff);
    send_op(FUNC_ENQ, 32'sh80000000);
    send_op(FUNC_ENQ, -1);
    send_op(FUNC_ENQ, '0);
    send_op(FUNC_DEQ, '0);
    send_op(FUNC_ENQ, 5);
    send_op(FUNC_ENQ, 32'sh7fffffff);
    repeat (7) send_op(FUNC_DEQ, -1);
    send_op(FUNC_ENQ, -7);
    send_op(FUNC_ENQ, -3);
    send_op(FUNC_DEQ, '0);
    send_op(FUNC_ENQ, -9);
    send_op(FUNC_DEQ, '0);
    send_op(FUNC_DEQ, '0);

    // hold results back long enough for the input side to stall
    fork
      begin
        hold_rx <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none

    run_phase(0, 0);
    run_phase(84, 0);
    run_phase(0, 84);
    run_phase(14, 14);
    item_if.valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
